// ===== design/ogq_pkg.sv =====
// Shared types, codes and helper functions for the occupancy grid neighbour query core.
package ogq_pkg;

  // Default grid store dimension (rows and columns of the square store)
  localparam int GRID_DIM_DEF = 64;

  // Field widths
  localparam int COORD_W     = 8;
  localparam int LIM_W       = 9;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 8;
  localparam int KIND_W      = 2;
  localparam int OUT_COORD_W = 6;

  // Reset value of both dimension registers
  localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 8'd1;

  // Operation codes
  localparam logic [1:0] OP_SET_OBSTACLE = 2'd0;
  localparam logic [1:0] OP_SET_PATH     = 2'd1;
  localparam logic [1:0] OP_QUERY        = 2'd2;
  localparam logic [1:0] OP_NEIGHBOURS   = 2'd3;

  // Cell kinds
  localparam logic [KIND_W-1:0] KIND_FREE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OBSTACLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PATH     = 2'd2;

  // Neighbour directions in report order
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
  } in_t;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] out_row;
    logic [OUT_COORD_W-1:0] out_col;
    logic [KIND_W-1:0]      cell_kind;
    logic                   entry_valid;
    logic                   last_result;
    logic                   off_grid_error;
  } out_t;

  // Effective bounds of the grid in use
  typedef struct packed {
    logic [LIM_W-1:0] row_lim;
    logic [LIM_W-1:0] col_lim;
  } grid_lim_t;

  // Grid memory control
  typedef struct packed {
    logic              we;
    logic              re;
    logic [KIND_W-1:0] wdata;
  } mem_ctl_t;

  // Neighbour candidate
  typedef struct packed {
    logic [LIM_W-1:0] row;
    logic [LIM_W-1:0] col;
    logic             ok;
  } nbr_t;

  // Step one cell in a direction; ok drops when the step would go below zero
  function automatic nbr_t nbr_step(input logic [COORD_W-1:0] r,
                                    input logic [COORD_W-1:0] c,
                                    input logic [1:0]         dir);
    nbr_t n;
    n.row = {1'b0, r};
    n.col = {1'b0, c};
    n.ok  = 1'b1;
    unique case (dir)
      DIR_UP: begin
        n.ok  = (r != '0);
        n.row = {1'b0, r} - 9'd1;
      end
      DIR_LEFT: begin
        n.ok  = (c != '0);
        n.col = {1'b0, c} - 9'd1;
      end
      DIR_RIGHT: begin
        n.col = {1'b0, c} + 9'd1;
      end
      DIR_DOWN: begin
        n.row = {1'b0, r} + 9'd1;
      end
    endcase
    return n;
  endfunction

  // True when the cell lies inside the bounds in use
  function automatic logic on_grid(input logic [LIM_W-1:0] row,
                                   input logic [LIM_W-1:0] col,
                                   input grid_lim_t        lim);
    return (row < lim.row_lim) && (col < lim.col_lim);
  endfunction

endpackage

// ===== design/ogq_grid_mem.sv =====
// Single-port grid cell memory with registered read data.
module ogq_grid_mem #(
  parameter int GRID_DIM = 64
) (
  input  logic                                    clk_i,
  input  ogq_pkg::mem_ctl_t                       ctl_i,
  input  logic [$clog2(GRID_DIM*GRID_DIM)-1:0]    addr_i,
  output logic [ogq_pkg::KIND_W-1:0]              rdata_o
);
  import ogq_pkg::*;

  localparam int DEPTH = GRID_DIM * GRID_DIM;

  logic [KIND_W-1:0] mem [DEPTH];
  logic [KIND_W-1:0] rdata_q;

  // Write or read one cell per cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= ctl_i.wdata;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ogq_seq.sv =====
// Sequencer: clearing pass, cell updates, queries, neighbour scan and result register.
module ogq_seq #(
  parameter int GRID_DIM = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ogq_pkg::grid_lim_t                   lim_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  ogq_pkg::in_t                         in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output ogq_pkg::out_t                        out_data_o,
  output ogq_pkg::mem_ctl_t                    mem_ctl_o,
  output logic [$clog2(GRID_DIM*GRID_DIM)-1:0] mem_addr_o,
  input  logic [ogq_pkg::KIND_W-1:0]           mem_rdata_i
);
  import ogq_pkg::*;

  localparam int DEPTH = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_QRES     = 3'd2;
  localparam logic [2:0] S_ERR      = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_SCAN_END = 3'd5;
  localparam logic [2:0] S_EMIT     = 3'd6;

  function automatic logic [AW-1:0] cell_addr(input logic [LIM_W-1:0] row,
                                              input logic [LIM_W-1:0] col);
    return AW'(int'(row) * GRID_DIM + int'(col));
  endfunction

  logic [2:0]         state_q, state_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [COORD_W-1:0] row_q, row_d, col_q, col_d;
  logic [1:0]         dir_q, dir_d, pdir_q, pdir_d;
  logic               pend_q, pend_d;
  logic [3:0]         mask_q, mask_d;
  logic               out_valid_q;
  out_t               out_q, out_d;
  logic               load;
  logic               slot_free;
  logic               accept;
  logic               in_on_grid;
  logic [1:0]         sel;
  logic [3:0]         sel_hot;
  logic [1:0]         step_dir;
  nbr_t               nb;
  logic               cand;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_on_grid = on_grid({1'b0, in_data_i.cell_row}, {1'b0, in_data_i.cell_col}, lim_i);

  // Pick the first remaining neighbour in report order
  always_comb begin
    sel     = DIR_UP;
    sel_hot = 4'b0001;
    priority if (mask_q[0]) begin
      sel     = DIR_UP;
      sel_hot = 4'b0001;
    end else if (mask_q[1]) begin
      sel     = DIR_LEFT;
      sel_hot = 4'b0010;
    end else if (mask_q[2]) begin
      sel     = DIR_RIGHT;
      sel_hot = 4'b0100;
    end else begin
      sel     = DIR_DOWN;
      sel_hot = 4'b1000;
    end
  end

  // Shared neighbour step and bounds check
  assign step_dir = (state_q == S_EMIT) ? sel : dir_q;
  assign nb       = nbr_step(row_q, col_q, step_dir);
  assign cand     = nb.ok && on_grid(nb.row, nb.col, lim_i);

  // Sequence the work of one item
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    row_d     = row_q;
    col_d     = col_q;
    dir_d     = dir_q;
    pdir_d    = pdir_q;
    pend_d    = pend_q;
    mask_d    = mask_q;
    load      = 1'b0;
    out_d     = '0;
    mem_ctl_o = '0;
    mem_addr_o = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_ctl_o.we    = 1'b1;
        mem_ctl_o.wdata = KIND_FREE;
        mem_addr_o      = clr_q;
        clr_d           = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_addr_o = cell_addr({1'b0, in_data_i.cell_row}, {1'b0, in_data_i.cell_col});
        if (accept) begin
          row_d  = in_data_i.cell_row;
          col_d  = in_data_i.cell_col;
          dir_d  = DIR_UP;
          pend_d = 1'b0;
          mask_d = '0;
          if (!in_on_grid) begin
            state_d = S_ERR;
          end else begin
            unique case (in_data_i.opcode)
              OP_SET_OBSTACLE: begin
                mem_ctl_o.we    = 1'b1;
                mem_ctl_o.wdata = KIND_OBSTACLE;
              end
              OP_SET_PATH: begin
                mem_ctl_o.we    = 1'b1;
                mem_ctl_o.wdata = KIND_PATH;
              end
              OP_QUERY: begin
                mem_ctl_o.re = 1'b1;
                state_d      = S_QRES;
              end
              OP_NEIGHBOURS: begin
                state_d = S_SCAN;
              end
            endcase
          end
        end
      end
      S_QRES: begin
        if (slot_free) begin
          load              = 1'b1;
          out_d.out_row     = row_q[OUT_COORD_W-1:0];
          out_d.out_col     = col_q[OUT_COORD_W-1:0];
          out_d.cell_kind   = mem_rdata_i;
          out_d.entry_valid = 1'b1;
          out_d.last_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_ERR: begin
        if (slot_free) begin
          load                 = 1'b1;
          out_d.last_result    = 1'b1;
          out_d.off_grid_error = 1'b1;
          state_d              = S_IDLE;
        end
      end
      S_SCAN: begin
        // Issue the read for this direction, judge the one read last cycle
        mem_ctl_o.re = cand;
        mem_addr_o   = cell_addr(nb.row, nb.col);
        if (pend_q && (mem_rdata_i == KIND_FREE)) begin
          mask_d[pdir_q] = 1'b1;
        end
        pend_d = cand;
        pdir_d = dir_q;
        dir_d  = dir_q + 1'b1;
        if (dir_q == DIR_DOWN) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        if (pend_q && (mem_rdata_i == KIND_FREE)) begin
          mask_d[pdir_q] = 1'b1;
        end
        pend_d  = 1'b0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          load = 1'b1;
          if (mask_q == '0) begin
            out_d.last_result = 1'b1;
            state_d           = S_IDLE;
          end else begin
            out_d.out_row     = nb.row[OUT_COORD_W-1:0];
            out_d.out_col     = nb.col[OUT_COORD_W-1:0];
            out_d.cell_kind   = KIND_FREE;
            out_d.entry_valid = 1'b1;
            out_d.last_result = ((mask_q & ~sel_hot) == '0);
            mask_d            = mask_q & ~sel_hot;
            if ((mask_q & ~sel_hot) == '0) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      dir_q       <= DIR_UP;
      pdir_q      <= DIR_UP;
      pend_q      <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      dir_q   <= dir_d;
      pdir_q  <= pdir_d;
      pend_q  <= pend_d;
      mask_q  <= mask_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    col_q <= col_d;
    if (load) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== design/occupancy_grid_neighbor_query_core.sv =====
// Top level of the occupancy grid neighbour query core: dimension registers and wiring.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+--------------------------
//   in       | in        | in_valid_i / in_ready_o   | in_data_i  (ogq_pkg::in_t)
//   out      | out       | out_valid_o / out_ready_i | out_data_o (ogq_pkg::out_t)
//   cfg      | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item at a time, set by the single grid memory port and its registered read data:
// a cell write is made as it is accepted, a query loads its result in S_QRES, an off-grid
// item its error in S_ERR, and a neighbour list reads up to four cells, one per cycle, then
// gives one result per cycle while the output does not stall. After reset the grid memory
// is cleared one cell per cycle with in_ready_o low; configuration transfers are taken at
// all times. A stalled output holds its result register and the sequencer waits on it.
module occupancy_grid_neighbor_query_core #(
  parameter int GRID_DIM = ogq_pkg::GRID_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ogq_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ogq_pkg::out_t                   out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ogq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ogq_pkg::CFG_W-1:0]       cfg_data_i
);
  import ogq_pkg::*;

  localparam int AW = $clog2(GRID_DIM * GRID_DIM);

  logic [CFG_W-1:0] height_q, height_d;
  logic [CFG_W-1:0] width_q, width_d;
  grid_lim_t        lim;
  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    mem_addr;
  logic [KIND_W-1:0] mem_rdata;

  assign cfg_ready_o = 1'b1;

  // Decode configuration transfers
  always_comb begin
    height_d = height_q;
    width_d  = width_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == REG_GRID_HEIGHT) begin
        height_d = cfg_data_i;
      end else if (cfg_index_i == REG_GRID_WIDTH) begin
        width_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= DIM_RESET;
      width_q  <= DIM_RESET;
    end else begin
      height_q <= height_d;
      width_q  <= width_d;
    end
  end

  // Clamp the dimensions to the store size
  assign lim.row_lim = (int'(height_q) > GRID_DIM) ? LIM_W'(GRID_DIM) : LIM_W'(height_q);
  assign lim.col_lim = (int'(width_q) > GRID_DIM) ? LIM_W'(GRID_DIM) : LIM_W'(width_q);

  ogq_seq #(
    .GRID_DIM (GRID_DIM)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lim_i       (lim),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .mem_rdata_i (mem_rdata)
  );

  ogq_grid_mem #(
    .GRID_DIM (GRID_DIM)
  ) u_grid_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .rdata_o (mem_rdata)
  );

endmodule
